// ===== rtl/r2fft_pkg.sv =====
// Package for the radix-2 FFT/IFFT engine: sizes, twiddle table, helpers.
// No dependencies.
`timescale 1ns / 1ps
package r2fft_pkg;
    localparam int POINTS_DEF = 64;
    localparam int MAX_LOG = 6;

    typedef logic signed [15:0] smp_t;

    function automatic logic signed [15:0] qcos(input logic [4:0] q);
        logic signed [15:0] v;
        unique case (q)
            5'd0: v = 16'sd16384;  5'd1: v = 16'sd16305;  5'd2: v = 16'sd16069;
            5'd3: v = 16'sd15679;  5'd4: v = 16'sd15137;  5'd5: v = 16'sd14449;
            5'd6: v = 16'sd13623;  5'd7: v = 16'sd12665;  5'd8: v = 16'sd11585;
            5'd9: v = 16'sd10394;  5'd10: v = 16'sd9102;  5'd11: v = 16'sd7723;
            5'd12: v = 16'sd6270;  5'd13: v = 16'sd4756;  5'd14: v = 16'sd3196;
            5'd15: v = 16'sd1606;  default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] tw_cos(input logic [4:0] q);
        logic [4:0] m;
        m = 5'd0 - q;
        return (q <= 5'd16) ? qcos(q) : -qcos(m);
    endfunction

    function automatic logic signed [15:0] tw_sin(input logic [4:0] q);
        logic [4:0] a;
        logic [4:0] b;
        a = 5'd16 - q;
        b = q - 5'd16;
        return (q <= 5'd16) ? qcos(a) : qcos(b);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
        if (x > 19'sd32767) return 16'sh7fff;
        if (x < -19'sd32768) return 16'sh8000;
        return x[15:0];
    endfunction
endpackage

// ===== rtl/r2fft_bfly.sv =====
// Registered butterfly datapath: complex multiply, then add/subtract with saturation.
// Depends on r2fft_pkg.
`timescale 1ns / 1ps
module r2fft_bfly
    import r2fft_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic signed [15:0] c,
    input  logic signed [15:0] sn,
    output logic [31:0] ya,
    output logic [31:0] yb
);
    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [31:0] a_reg;
    logic signed [15:0] br, bi, ar, ai;
    logic signed [32:0] tr_full, ti_full;
    logic signed [18:0] tr, ti;

    assign br = b[31:16];
    assign bi = b[15:0];

    // one multiplier row, registered before the sums
    always_ff @(posedge clk)
    begin
        p0_reg <= br * c;
        p1_reg <= bi * sn;
        p2_reg <= br * sn;
        p3_reg <= bi * c;
        a_reg  <= a;
    end

    assign ar = a_reg[31:16];
    assign ai = a_reg[15:0];
    assign tr_full = 33'(p0_reg) - 33'(p1_reg);
    assign ti_full = 33'(p2_reg) + 33'(p3_reg);
    assign tr = tr_full[32:14];
    assign ti = ti_full[32:14];
    assign ya = {sat16(19'(ar) + tr), sat16(19'(ai) + ti)};
    assign yb = {sat16(19'(ar) - tr), sat16(19'(ai) - ti)};
endmodule

// ===== rtl/radix2_fft_ifft_engine_top.sv =====
// Top level of the radix-2 FFT/IFFT engine: sample store, sequencer, output.
// Depends on r2fft_pkg and r2fft_bfly.
//
// channel  | signals                          | transaction
// input    | start, busy, sample_real/imag    | start & !busy
// config   | cfg_we, cfg_wdata                | cfg_we
// result   | out_valid, out_real/imag/last    | out_valid, one per cycle
//
// Loading takes one sample per cycle while start is high. After the last
// sample the block is busy for log2(POINTS) stages of POINTS/2 butterflies,
// each made of read A, read B, multiply, write A and write B, then for the
// output of the bins; the last bin shows in the cycle in which busy drops.
// Reset clears the sequencer; the store is not cleared.
`timescale 1ns / 1ps
module radix2_fft_ifft_engine_top
    import r2fft_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [15:0] sample_real,
    input  logic signed [15:0] sample_imag,
    input  logic cfg_we,
    input  logic cfg_wdata,
    output logic out_valid,
    output logic signed [15:0] out_real,
    output logic signed [15:0] out_imag,
    output logic out_last
);
    localparam int L = $clog2(POINTS);
    localparam int HB = (L > 1) ? L - 1 : 1;

    localparam logic [2:0] S_LOAD = 3'd0, S_RA = 3'd1, S_RB = 3'd2, S_MUL = 3'd3,
                           S_WA = 3'd4, S_WB = 3'd5, S_OUT = 3'd6, S_OUT2 = 3'd7;

    logic [31:0] mem [POINTS];
    logic [31:0] rd_data;
    logic        we;
    logic [L-1:0] waddr, raddr;
    logic [31:0] wdata;

    logic [2:0]  state_reg, state_next;
    logic        inv_reg, binv_reg;
    logic [L:0]  cnt_reg;             // load / output counter
    logic [$clog2(L+1)-1:0] stg_reg;  // stage index, half = 1 << stg
    logic [HB-1:0] bf_reg;           // butterfly within stage
    logic [31:0] a_reg;
    logic [31:0] ya, yb;
    logic [L-1:0] ia, ib, rev;
    logic [L-1:0] kidx, jidx;
    logic [L-1:0] half;
    logic [4:0]  q;
    logic signed [15:0] c, s, sn;
    logic signed [15:0] lre, lim;
    logic        ovalid_reg, olast_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data <= mem[raddr];
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
            rev[i] = cnt_reg[L-1-i];
    end

    // butterfly bf -> k = bf mod half, j = (bf / half) * 2 * half
    always_comb
    begin
        logic [L-1:0] bfx;
        bfx  = L'(bf_reg);
        half = L'(1) << stg_reg;
        kidx = bfx & (half - L'(1));
        jidx = (bfx & ~(half - L'(1))) << 1;
        ia = jidx | kidx;
        ib = ia | half;
        q = 5'((32'(kidx) << (5 - 32'(stg_reg))) & 32'h1f);
    end

    assign c  = tw_cos(q);
    assign s  = tw_sin(q);
    assign sn = binv_reg ? s : -s;

    // B comes straight from the store: valid in the multiply and write-A states
    r2fft_bfly u_bfly (.clk(clk), .a(a_reg), .b(rd_data), .c(c), .sn(sn), .ya(ya), .yb(yb));

    assign lre = inv_reg ? (sample_real >>> L) : sample_real;
    assign lim = inv_reg ? (sample_imag >>> L) : sample_imag;

    always_comb
    begin
        we = 1'b0;
        waddr = ia;
        wdata = ya;
        raddr = ia;
        unique case (state_reg)
            S_LOAD:
            begin
                we = start;
                waddr = rev;
                wdata = {lre, lim};
            end
            S_RA: raddr = ia;
            S_RB: raddr = ib;
            S_MUL: raddr = ib;
            S_WA:
            begin
                we = 1'b1;
                waddr = ia;
                wdata = ya;
            end
            S_WB:
            begin
                we = 1'b1;
                waddr = ib;
                wdata = yb;
            end
            S_OUT, S_OUT2: raddr = cnt_reg[L-1:0];
            default: raddr = ia;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (start && cnt_reg == (L+1)'(POINTS - 1)) state_next = S_RA;
            S_RA: state_next = S_RB;
            S_RB: state_next = S_MUL;
            S_MUL: state_next = S_WA;
            S_WA: state_next = S_WB;
            S_WB:
                if (bf_reg == HB'(POINTS / 2 - 1) && 32'(stg_reg) == L - 1)
                    state_next = S_OUT;
                else
                    state_next = S_RA;
            S_OUT: state_next = S_OUT2;
            S_OUT2: if (cnt_reg == (L+1)'(POINTS)) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            inv_reg    <= 1'b0;
            binv_reg   <= 1'b0;
            cnt_reg    <= '0;
            stg_reg    <= '0;
            bf_reg     <= '0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                inv_reg <= cfg_wdata;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                    if (start)
                    begin
                        if (cnt_reg == (L+1)'(POINTS - 1))
                        begin
                            cnt_reg  <= '0;
                            binv_reg <= inv_reg;
                            stg_reg  <= '0;
                            bf_reg   <= '0;
                        end
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                S_WB:
                    if (bf_reg == HB'(POINTS / 2 - 1))
                    begin
                        bf_reg <= '0;
                        stg_reg <= stg_reg + 1'b1;
                    end
                    else
                        bf_reg <= bf_reg + 1'b1;
                S_OUT: cnt_reg <= cnt_reg + 1'b1;
                S_OUT2:
                begin
                    // the read data arrives in the cycle after its address
                    ovalid_reg <= 1'b1;
                    olast_reg  <= (cnt_reg == (L+1)'(POINTS));
                    if (cnt_reg == (L+1)'(POINTS))
                        cnt_reg <= '0;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RB)
            a_reg <= rd_data;
        if (state_reg == S_OUT2)
            {out_real, out_imag} <= rd_data;
    end

    assign busy      = (state_reg != S_LOAD);
    assign out_valid = ovalid_reg;
    assign out_last  = olast_reg;
endmodule

// ===== rtl/r2fft_checker.sv =====
// Port-level checks for the FFT/IFFT engine, bound to the top level.
// Depends on radix2_fft_ifft_engine_top ports only.
`timescale 1ns / 1ps
module r2fft_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic out_valid,
    input logic out_last
);
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid) else $error("last without valid");
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> busy) else $error("result while idle");
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |=> !out_valid) else $error("result after last");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");
endmodule

bind radix2_fft_ifft_engine_top r2fft_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .out_last(out_last)
);
